/* hdl/cwmv_pkg.sv */
// Shared widths, constants and defaults of the context weighted majority vote.
package cwmv_pkg;

	localparam int DefExperts  = 8;
	localparam int DefContexts = 4;

	localparam int WeightW = 32;
	localparam int CountW  = 32;
	localparam int VoteW   = 8;
	localparam int ReqW    = 2;
	localparam int BestW   = 34;
	localparam int MaxExperts = 32;

	localparam logic [WeightW-1:0] WeightReset = '1;
	localparam logic [WeightW-1:0] DecayReset  = 32'h9B45_97E3;
	localparam logic [CountW-1:0]  CountMax    = '1;
	localparam logic [BestW-1:0]   BestMax     = '1;

endpackage

/* hdl/context_weighted_majority_vote.sv */
// Context weighted majority vote: top level with sequencer, shared multiplier and tables.
// Keeps CONTEXTS weighted-majority learners of EXPERTS weights each, in two memories with
// one write and one read port (weights and miss counts) walked one expert per cycle. A predict
// item takes one pass summing yes and no weight, then the output step. A train item adds an
// update pass through the one 32x32 multiplier, a normalisation search that shifts the
// largest weight one bit a cycle, a shift pass when any shift is needed and the
// bookkeeping states FIN1 and FIN2. The result is loaded only once no earlier result is
// still held, and the block passes through its idle state before the next item is taken.
// The block takes one item at a time; in_stall is high while an item is in work, while its
// result cannot yet be loaded or while the clearing pass runs. After reset a clearing pass
// fills the tables before the first item is taken; the decay register may be written at
// any time the block is idle. A finished result waits in the output register while the
// next item is already accepted.
module context_weighted_majority_vote #(
	parameter int EXPERTS  = cwmv_pkg::DefExperts,
	parameter int CONTEXTS = cwmv_pkg::DefContexts
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [cwmv_pkg::VoteW-1:0]    votes,
	input  logic                          truth,
	input  logic [cwmv_pkg::ReqW-1:0]     context_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          decision,
	output logic                          learner_wrong,
	output logic [cwmv_pkg::CountW-1:0]   learner_mistakes,
	output logic [cwmv_pkg::CountW-1:0]   no_right_count,
	output logic [cwmv_pkg::BestW-1:0]    best_loss_sum,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cwmv_pkg::WeightW-1:0]  cfg_data
);

	localparam int Depth = CONTEXTS * EXPERTS;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW    = $clog2(EXPERTS + 1);
	localparam int EW    = (EXPERTS > 1) ? $clog2(EXPERTS) : 1;
	localparam int CXW   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int SW    = cwmv_pkg::WeightW + $clog2(EXPERTS + 1);
	localparam int BW    = cwmv_pkg::CountW + $clog2(CONTEXTS);
	localparam int BSW   = (BW > cwmv_pkg::BestW) ? BW : cwmv_pkg::BestW;
	localparam int WW    = cwmv_pkg::WeightW;
	localparam int NW    = cwmv_pkg::CountW;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SUM   = 4'd2;
	localparam logic [3:0] ST_UPD   = 4'd3;
	localparam logic [3:0] ST_NORM  = 4'd4;
	localparam logic [3:0] ST_SHIFT = 4'd5;
	localparam logic [3:0] ST_FIN1  = 4'd6;
	localparam logic [3:0] ST_FIN2  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] v);
		return (v == cwmv_pkg::CountMax) ? v : v + NW'(1);
	endfunction

	function automatic logic [CXW-1:0] wrap_ctx(input logic [cwmv_pkg::ReqW-1:0] req);
		int v;
		v = int'(req);
		for (int k = 0; k < 4; k++) begin
			if (v >= CONTEXTS) begin
				v = v - CONTEXTS;
			end
		end
		return CXW'(v);
	endfunction

	logic [3:0]     state_q;
	logic [AW-1:0]  clr_q;
	logic [CW-1:0]  cnt_q;
	logic           rv_s1, rv_s2;
	logic [EW-1:0]  idx_s1;
	logic [AW-1:0]  addr_s1, addr_s2;
	logic [WW-1:0]  prod_s2;
	logic [NW-1:0]  miss_s2;
	logic [WW-1:0]  decay_q;
	logic [NW-1:0]  lm_q;
	logic [NW-1:0]  nr_q [CONTEXTS];
	logic [NW-1:0]  cmin_q [CONTEXTS];
	logic [BW-1:0]  sum_q;
	logic           out_valid_q;

	logic                        cmd_q, truth_q;
	logic [cwmv_pkg::VoteW-1:0]  votes_q;
	logic [CXW-1:0]              ctx_q;
	logic [AW-1:0]               base_q;
	logic [SW-1:0]               yes_q, no_q;
	logic                        dec_q, wrong_q, anyr_q;
	logic [WW-1:0]               mx_q;
	logic [NW-1:0]               mn_q, delta_q;
	logic [4:0]                  sh_q;
	logic                        o_dec_q, o_wrong_q;
	logic [NW-1:0]               o_lm_q, o_nr_q;
	logic [cwmv_pkg::BestW-1:0]  o_best_q;

	logic                          accept, issue, pass_done, load_out, vote_i, wrong_i;
	logic                          dec_c, norm_done;
	logic [AW-1:0]                 addr;
	logic [cwmv_pkg::MaxExperts-1:0] votes_ext;
	logic [WW-1:0]                 w_rd;
	logic [NW-1:0]                 m_rd;
	logic [2*WW-1:0]               mul;
	logic                          w_we, m_we;
	logic [AW-1:0]                 w_waddr, m_waddr;
	logic [WW-1:0]                 w_wdata;
	logic [NW-1:0]                 m_wdata;
	logic [BSW-1:0]                sum_ext;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign issue     = (state_q == ST_SUM || state_q == ST_UPD || state_q == ST_SHIFT) &&
	                   (cnt_q < CW'(EXPERTS));
	assign pass_done = (cnt_q == CW'(EXPERTS)) && !rv_s1 && !rv_s2;
	assign addr      = base_q + AW'(cnt_q);
	assign votes_ext = {{(cwmv_pkg::MaxExperts - cwmv_pkg::VoteW){1'b0}}, votes_q};
	assign vote_i    = votes_ext[5'(idx_s1)];
	assign wrong_i   = (vote_i != truth_q);
	assign mul       = (2*WW)'(w_rd) * (2*WW)'(decay_q);
	assign dec_c     = (yes_q >= no_q);
	assign norm_done = (mx_q == '0) || mx_q[WW-1];
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign sum_ext   = BSW'(sum_q);

	always_comb begin
		w_we = 1'b0; w_waddr = addr_s2; w_wdata = prod_s2;
		m_we = 1'b0; m_waddr = addr_s2; m_wdata = miss_s2;
		case (state_q)
			ST_CLEAR: begin
				w_we = 1'b1; w_waddr = clr_q; w_wdata = cwmv_pkg::WeightReset;
				m_we = 1'b1; m_waddr = clr_q; m_wdata = '0;
			end
			ST_UPD: begin
				w_we = rv_s2;
				m_we = rv_s2;
			end
			ST_SHIFT: begin
				w_we = rv_s1; w_waddr = addr_s1; w_wdata = w_rd << sh_q;
			end
			default: begin
				w_we = 1'b0;
				m_we = 1'b0;
			end
		endcase
	end

	cwmv_ram #(.DEPTH(Depth), .AW(AW), .DW(WW)) u_weights (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(issue ? addr : '0), .rdata(w_rd)
	);

	cwmv_ram #(.DEPTH(Depth), .AW(AW), .DW(NW)) u_misses (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(issue ? addr : '0), .rdata(m_rd)
	);

	// sequencer and persistent counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rv_s1       <= 1'b0;
			rv_s2       <= 1'b0;
			decay_q     <= cwmv_pkg::DecayReset;
			lm_q        <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CONTEXTS; c++) begin
				nr_q[c]   <= '0;
				cmin_q[c] <= '0;
			end
		end else begin
			rv_s1 <= issue;
			rv_s2 <= rv_s1;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				decay_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(Depth - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (pass_done) begin
						cnt_q <= '0;
						if (cmd_q) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_UPD;
							if (dec_c != truth_q) begin
								lm_q <= sat_inc(lm_q);
							end
						end
					end
				end
				ST_UPD: begin
					if (pass_done) begin
						cnt_q   <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (norm_done) begin
						cnt_q   <= '0;
						state_q <= (sh_q != '0) ? ST_SHIFT : ST_FIN1;
					end
				end
				ST_SHIFT: begin
					if (pass_done) begin
						state_q <= ST_FIN1;
					end
				end
				ST_FIN1: begin
					cmin_q[ctx_q] <= mn_q;
					if (!anyr_q) begin
						nr_q[ctx_q] <= sat_inc(nr_q[ctx_q]);
					end
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					sum_q   <= sum_q + BW'(delta_q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item data path
	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q[EW-1:0];
		addr_s1 <= addr;
		addr_s2 <= addr_s1;
		prod_s2 <= wrong_i ? mul[2*WW-1:WW] : w_rd;
		miss_s2 <= wrong_i ? sat_inc(m_rd) : m_rd;
		if (accept) begin
			cmd_q   <= cmd;
			votes_q <= votes;
			truth_q <= truth;
			ctx_q   <= wrap_ctx(context_req);
			base_q  <= AW'(wrap_ctx(context_req)) * AW'(EXPERTS);
			yes_q   <= '0;
			no_q    <= '0;
		end
		case (state_q)
			ST_SUM: begin
				if (rv_s1) begin
					if (vote_i) begin
						yes_q <= yes_q + SW'(w_rd);
					end else begin
						no_q <= no_q + SW'(w_rd);
					end
				end
				if (pass_done) begin
					dec_q   <= dec_c;
					wrong_q <= !cmd_q && (dec_c != truth_q);
					mx_q    <= '0;
					mn_q    <= cwmv_pkg::CountMax;
					anyr_q  <= 1'b0;
					sh_q    <= '0;
				end
			end
			ST_UPD: begin
				if (rv_s1 && !wrong_i) begin
					anyr_q <= 1'b1;
				end
				if (rv_s2) begin
					if (prod_s2 > mx_q) begin
						mx_q <= prod_s2;
					end
					if (miss_s2 < mn_q) begin
						mn_q <= miss_s2;
					end
				end
			end
			ST_NORM: begin
				if (!norm_done) begin
					mx_q <= mx_q << 1;
					sh_q <= sh_q + 5'd1;
				end
			end
			ST_FIN1: begin
				delta_q <= mn_q - cmin_q[ctx_q];
			end
			ST_OUT: begin
				if (load_out) begin
					o_dec_q   <= dec_q;
					o_wrong_q <= wrong_q;
					o_lm_q    <= lm_q;
					o_nr_q    <= nr_q[ctx_q];
					o_best_q  <= (sum_ext > BSW'(cwmv_pkg::BestMax)) ?
					             cwmv_pkg::BestMax : sum_ext[cwmv_pkg::BestW-1:0];
				end
			end
			default: begin
				delta_q <= delta_q;
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign decision         = o_dec_q;
	assign learner_wrong    = o_wrong_q;
	assign learner_mistakes = o_lm_q;
	assign no_right_count   = o_nr_q;
	assign best_loss_sum    = o_best_q;

endmodule

/* hdl/cwmv_ram.sv */
// Single write port, single registered read port memory.
module cwmv_ram #(
	parameter int DEPTH = cwmv_pkg::DefExperts * cwmv_pkg::DefContexts,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int DW    = cwmv_pkg::WeightW
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/cwmv_checker.sv */
// Port-level checks of the context weighted majority vote, bound to the top level.
module cwmv_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         decision,
	input logic                         learner_wrong,
	input logic [cwmv_pkg::CountW-1:0]  learner_mistakes,
	input logic [cwmv_pkg::CountW-1:0]  no_right_count,
	input logic [cwmv_pkg::BestW-1:0]   best_loss_sum
);

	// a held result must not move
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(decision) && $stable(learner_wrong) &&
		$stable(learner_mistakes) && $stable(no_right_count) && $stable(best_loss_sum))
		else $error("result changed while stalled");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while busy");

	// a wrong learner item is counted in the total
	a_wrong_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && learner_wrong |-> learner_mistakes != '0)
		else $error("learner miss not counted");

endmodule

bind context_weighted_majority_vote cwmv_checker u_cwmv_checker (.*);

/* test/tb_context_weighted_majority_vote.sv */
// Self-checking testbench for the context weighted majority vote block.
`timescale 1ns / 1ps

module tb_context_weighted_majority_vote;

	localparam int EXPERTS      = cwmv_pkg::DefExperts;
	localparam int CONTEXTS     = cwmv_pkg::DefContexts;
	localparam int WeightW      = cwmv_pkg::WeightW;
	localparam int CountW       = cwmv_pkg::CountW;
	localparam int BestW        = cwmv_pkg::BestW;
	localparam int VoteW        = cwmv_pkg::VoteW;
	localparam int ReqW         = cwmv_pkg::ReqW;
	localparam logic [WeightW-1:0] WeightReset = cwmv_pkg::WeightReset;
	localparam logic [WeightW-1:0] DecayReset  = cwmv_pkg::DecayReset;
	localparam logic [CountW-1:0]  CountMax    = cwmv_pkg::CountMax;
	localparam logic [BestW-1:0]   BestMax     = cwmv_pkg::BestMax;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 4 * EXPERTS + 64;
	localparam logic [WeightW-1:0] HalfWeight = 32'h8000_0000;

	typedef enum logic {
		CMD_TRAIN   = 1'b0,
		CMD_PREDICT = 1'b1
	} cmd_t;

	typedef struct {
		logic              decision;
		logic              learner_wrong;
		logic [CountW-1:0] learner_mistakes;
		logic [CountW-1:0] no_right_count;
		logic [BestW-1:0]  best_loss_sum;
	} verdict_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                cmd = 1'b0;
	logic [VoteW-1:0]    votes = '0;
	logic                truth = 1'b0;
	logic [ReqW-1:0]     context_req = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                decision;
	logic                learner_wrong;
	logic [CountW-1:0]   learner_mistakes;
	logic [CountW-1:0]   no_right_count;
	logic [BestW-1:0]    best_loss_sum;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [WeightW-1:0]  cfg_data = '0;

	// mirror of the learners
	logic [WeightW-1:0]  weight_m [CONTEXTS][EXPERTS];
	logic [CountW-1:0]   miss_m [CONTEXTS][EXPERTS];
	logic [CountW-1:0]   no_right_m [CONTEXTS];
	logic [CountW-1:0]   learner_miss_m;
	logic [WeightW-1:0]  decay_m;

	verdict_t pending_verdicts [$];
	int errors = 0;
	int quiet_cycles = 0;
	bit rx_hold_req = 1'b0;

	context_weighted_majority_vote #(
		.EXPERTS  (EXPERTS),
		.CONTEXTS (CONTEXTS)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.votes            (votes),
		.truth            (truth),
		.context_req      (context_req),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.decision         (decision),
		.learner_wrong    (learner_wrong),
		.learner_mistakes (learner_mistakes),
		.no_right_count   (no_right_count),
		.best_loss_sum    (best_loss_sum),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CountW-1:0] bump(logic [CountW-1:0] n);
		return (n == CountMax) ? n : n + 1'b1;
	endfunction

	// weighs the votes with the context's weights, then learns from the truth on train
	function automatic verdict_t weigh_votes(cmd_t op, logic [VoteW-1:0] v, logic t,
			logic [ReqW-1:0] req);
		verdict_t r;
		int unsigned ctx;
		logic [WeightW+8:0] yes_w, no_w;
		logic [WeightW-1:0] top;
		logic [BestW:0] best;
		logic [CountW-1:0] least;
		logic vote, any_right;
		int shift;
		ctx = req % CONTEXTS;
		yes_w = '0;
		no_w = '0;
		for (int i = 0; i < EXPERTS; i++) begin
			vote = (i < VoteW) ? v[i] : 1'b0;
			if (vote)
				yes_w += weight_m[ctx][i];
			else
				no_w += weight_m[ctx][i];
		end
		r.decision = (yes_w >= no_w);
		r.learner_wrong = 1'b0;
		if (op == CMD_TRAIN) begin
			any_right = 1'b0;
			r.learner_wrong = (r.decision != t);
			if (r.learner_wrong)
				learner_miss_m = bump(learner_miss_m);
			for (int i = 0; i < EXPERTS; i++) begin
				vote = (i < VoteW) ? v[i] : 1'b0;
				if (vote != t) begin
					weight_m[ctx][i] =
						WeightW'((64'(weight_m[ctx][i]) * 64'(decay_m)) >> 32);
					miss_m[ctx][i] = bump(miss_m[ctx][i]);
				end else begin
					any_right = 1'b1;
				end
			end
			top = '0;
			for (int i = 0; i < EXPERTS; i++)
				if (weight_m[ctx][i] > top)
					top = weight_m[ctx][i];
			if (top != '0) begin
				shift = 0;
				while (top < HalfWeight) begin
					top = top << 1;
					shift++;
				end
				for (int i = 0; i < EXPERTS; i++)
					weight_m[ctx][i] = weight_m[ctx][i] << shift;
			end
			if (!any_right)
				no_right_m[ctx] = bump(no_right_m[ctx]);
		end
		best = '0;
		for (int c = 0; c < CONTEXTS; c++) begin
			least = miss_m[c][0];
			for (int i = 1; i < EXPERTS; i++)
				if (miss_m[c][i] < least)
					least = miss_m[c][i];
			best += least;
		end
		r.learner_mistakes = learner_miss_m;
		r.no_right_count = no_right_m[ctx];
		r.best_loss_sum = (best > BestMax) ? BestMax : best[BestW-1:0];
		return r;
	endfunction

	function automatic void check_field(string what, logic [BestW-1:0] want,
			logic [BestW-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			errors++;
		end
	endfunction

	// valid is left high so a following item goes out without a gap
	task automatic send_item(cmd_t op, logic [VoteW-1:0] v, logic t, logic [ReqW-1:0] req);
		in_valid    <= 1'b1;
		cmd         <= op;
		votes       <= v;
		truth       <= t;
		context_req <= req;
		do
			@(posedge clk);
		while (in_stall);
		pending_verdicts.insert(pending_verdicts.size(), weigh_votes(op, v, t, req));
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_decay(logic [WeightW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		decay_m = value;
	endtask

	task automatic test_initial_weights();
		// equal weights: all no, all yes, and a four-four tie
		send_item(CMD_PREDICT, 8'h00, 1'b1, 2'd0);
		send_item(CMD_PREDICT, 8'hFF, 1'b0, 2'd1);
		send_item(CMD_PREDICT, 8'h0F, 1'b0, 2'd2);
	endtask

	task automatic test_training_rules();
		send_item(CMD_TRAIN, 8'hAA, 1'b1, 2'd0);
		send_item(CMD_TRAIN, 8'h55, 1'b1, 2'd0);
		send_item(CMD_TRAIN, 8'hFF, 1'b0, 2'd0);   // nobody right
		send_item(CMD_TRAIN, 8'h00, 1'b1, 2'd1);   // nobody right
		send_item(CMD_TRAIN, 8'hFF, 1'b1, 2'd1);
		send_item(CMD_TRAIN, 8'h81, 1'b0, 2'd1);
		send_item(CMD_PREDICT, 8'hAA, 1'b1, 2'd0);
		send_item(CMD_PREDICT, 8'h3C, 1'b0, 2'd1);
	endtask

	task automatic test_decay_extremes();
		wait_results_drained();
		write_decay(32'hFFFF_FFFF);
		send_item(CMD_TRAIN, 8'hF0, 1'b1, 2'd2);
		send_item(CMD_TRAIN, 8'hF0, 1'b1, 2'd2);
		send_item(CMD_PREDICT, 8'hF0, 1'b0, 2'd2);
		wait_results_drained();
		write_decay(32'h0000_0001);
		send_item(CMD_TRAIN, 8'h0F, 1'b1, 2'd2);   // wrong experts drop to zero
		send_item(CMD_TRAIN, 8'h00, 1'b1, 2'd3);   // whole context drops to zero
		send_item(CMD_PREDICT, 8'h00, 1'b0, 2'd3); // zero against zero decides yes
		send_item(CMD_TRAIN, 8'hFF, 1'b0, 2'd3);
		wait_results_drained();
		write_decay(DecayReset);
	endtask

	task automatic test_output_backpressure();
		wait_results_drained();
		rx_hold_req <= 1'b1;
		@(posedge clk);
		rx_hold_req <= 1'b0;
		for (int k = 0; k < 12; k++)
			send_item(cmd_t'($urandom_range(0, 3) == 0), VoteW'($urandom),
				1'($urandom_range(0, 1)), ReqW'($urandom_range(0, CONTEXTS - 1)));
		wait_results_drained();
	endtask

	task automatic test_random_traffic();
		logic [WeightW-1:0] decays [5];
		logic [VoteW-1:0] good, v;
		logic t;
		int burst_left;
		decays = '{DecayReset, $urandom_range(1, 32'hFFFF_FFFF), 32'hFFFF_FFFF,
			32'h4000_0000, $urandom_range(1, 32'hFFFF_FFFF)};
		burst_left = 0;
		foreach (decays[p]) begin
			wait_results_drained();
			write_decay(decays[p]);
			good = VoteW'($urandom);
			for (int k = 0; k < 250; k++) begin
				if (burst_left == 0) begin
					pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
						: $urandom_range(0, 12));
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				t = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 9))
					0: v = {VoteW{~t}};
					1, 2, 3, 4, 5: v = (({VoteW{t}} & good) | ({VoteW{~t}} & ~good))
						^ VoteW'($urandom & $urandom & $urandom);
					default: v = VoteW'($urandom);
				endcase
				send_item(cmd_t'($urandom_range(0, 3) == 0),
					v, t, ReqW'($urandom_range(0, CONTEXTS - 1)));
			end
		end
	endtask

	// result side: random stall pattern, plus a long hold on request
	always @(posedge clk) begin
		static int rx_mode = 0;
		static int mode_left = 0;
		static int hold_left = 0;
		if (rx_hold_req) begin
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(8, 80);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t ns: result item with nothing expected", $time);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("decision", BestW'(want.decision), BestW'(decision));
				check_field("learner_wrong", BestW'(want.learner_wrong),
					BestW'(learner_wrong));
				check_field("learner_mistakes", BestW'(want.learner_mistakes),
					BestW'(learner_mistakes));
				check_field("no_right_count", BestW'(want.no_right_count),
					BestW'(no_right_count));
				check_field("best_loss_sum", want.best_loss_sum, best_loss_sum);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: watchdog, no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < CONTEXTS; c++) begin
			no_right_m[c] = '0;
			for (int i = 0; i < EXPERTS; i++) begin
				weight_m[c][i] = WeightReset;
				miss_m[c][i] = '0;
			end
		end
		learner_miss_m = '0;
		decay_m = DecayReset;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_initial_weights();
		test_training_rules();
		test_decay_extremes();
		test_output_backpressure();
		test_random_traffic();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
